### rtl/oidber_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// oidber_pkg
// Shared types and constants of the dotted OID to BER encoder.
// -----------------------------------------------------------------------------
package oidber_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // one finished arc waiting to be serialised
  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } arc_job_t;

  // what the front hands to the queue in one beat
  typedef struct packed {
    logic [1:0] n;
    arc_job_t   j0;
    arc_job_t   j1;
  } arc_push_t;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

endpackage

### rtl/oidber_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// oidber_front
// Takes characters, builds arcs in decimal and queues finished arcs.
// -----------------------------------------------------------------------------
module oidber_front import oidber_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  char_item,
  output arc_push_t arcs
);

  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_LATER  = 2'd2;

  logic [31:0] accum, accum_next;
  logic        done, done_next;
  logic [1:0]  idx, idx_next;
  logic [31:0] first40, first40_next;
  logic        accept, is_dot, is_dig;
  arc_job_t    dot_job, last_job;
  logic        dot_v;

  assign accept = push && !full;
  assign is_dot = (char_item.ch == CH_DOT);
  assign is_dig = (char_item.ch >= CH_ZERO) && (char_item.ch <= CH_NINE);

  always_comb begin
    accum_next   = accum;
    done_next    = done;
    idx_next     = idx;
    first40_next = first40;
    dot_v        = 1'b0;
    dot_job      = '{value: accum, last: 1'b0};
    if (is_dot) begin
      unique case (idx)
        IDX_FIRST: first40_next = (accum << 5) + (accum << 3);
        IDX_SECOND: begin
          dot_v         = 1'b1;
          dot_job.value = first40 + accum;
        end
        default: dot_v = 1'b1;
      endcase
      idx_next   = (idx == IDX_LATER) ? idx : idx + 2'd1;
      accum_next = '0;
      done_next  = 1'b0;
    end else if (is_dig) begin
      if (!done) begin
        accum_next = (accum << 3) + (accum << 1) + {28'd0, char_item.ch[3:0]};
      end
    end else begin
      done_next = 1'b1;
    end
    last_job.last  = 1'b1;
    last_job.value = (idx_next == IDX_SECOND) ? first40_next + accum_next : accum_next;
  end

  always_comb begin
    arcs.n  = 2'd0;
    arcs.j0 = dot_v ? dot_job : last_job;
    arcs.j1 = last_job;
    if (accept) begin
      arcs.n = {1'b0, dot_v} + {1'b0, char_item.is_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum   <= '0;
      done    <= 1'b0;
      idx     <= IDX_FIRST;
      first40 <= '0;
    end else if (accept) begin
      if (char_item.is_last) begin
        accum   <= '0;
        done    <= 1'b0;
        idx     <= IDX_FIRST;
        first40 <= '0;
      end else begin
        accum   <= accum_next;
        done    <= done_next;
        idx     <= idx_next;
        first40 <= first40_next;
      end
    end
  end

  a_idx_sat: assert property (@(posedge clk) disable iff (rst) idx != 2'd3)
    else $error("arc index past saturation");

endmodule

### rtl/oidber_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// oidber_queue
// Short arc queue between front and back; takes up to two arcs a beat.
// -----------------------------------------------------------------------------
module oidber_queue import oidber_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  arc_push_t arcs,
  input  logic      rd,
  output arc_job_t  head,
  output logic      head_valid,
  output logic      full
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

  arc_job_t         slots [DEPTH];
  logic [IDX_W-1:0] wp, rp;
  logic [CNT_W-1:0] cnt;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign head       = slots[rp];
  assign head_valid = (cnt != '0);
  assign full       = (cnt > CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (arcs.n != 2'd0) begin
      slots[wp] <= arcs.j0;
    end
    if (arcs.n == 2'd2) begin
      slots[wrap_inc(wp)] <= arcs.j1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      unique case (arcs.n)
        2'd1:    wp <= wrap_inc(wp);
        2'd2:    wp <= wrap_inc(wrap_inc(wp));
        default: wp <= wp;
      endcase
      if (rd) begin
        rp <= wrap_inc(rp);
      end
      cnt <= cnt + CNT_W'(arcs.n) - CNT_W'(rd);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(DEPTH))
    else $error("arc queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst) rd |-> head_valid)
    else $error("arc queue read while empty");

endmodule

### rtl/oidber_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// oidber_back
// Serialises queued arcs into base-128 bytes, one beat per cycle while the output is popped.
// -----------------------------------------------------------------------------
module oidber_back import oidber_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  arc_job_t  head,
  input  logic      head_valid,
  output logic      rd,
  input  logic      pop,
  output logic      empty,
  output out_item_t byte_item
);

  logic        busy;
  logic [2:0]  grp;
  arc_job_t    held;
  logic        out_valid;
  out_item_t   out_reg;

  logic        take, have;
  arc_job_t    src;
  logic [2:0]  src_g;
  logic [6:0]  chunk;

  function automatic logic [2:0] top_group(input logic [31:0] v);
    if (v < 32'h80)            return 3'd0;
    else if (v < 32'h4000)     return 3'd1;
    else if (v < 32'h200000)   return 3'd2;
    else if (v < 32'h10000000) return 3'd3;
    else                       return 3'd4;
  endfunction

  assign take  = !out_valid || pop;
  assign have  = busy || head_valid;
  assign src   = busy ? held : head;
  assign src_g = busy ? grp : top_group(head.value);
  assign rd    = take && !busy && head_valid;

  always_comb begin
    unique case (src_g)
      3'd0:    chunk = src.value[6:0];
      3'd1:    chunk = src.value[13:7];
      3'd2:    chunk = src.value[20:14];
      3'd3:    chunk = src.value[27:21];
      default: chunk = {3'd0, src.value[31:28]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (take && have) begin
      out_reg.out_byte <= {(src_g != 3'd0), chunk};
      out_reg.out_last <= src.last && (src_g == 3'd0);
      held             <= src;
      grp              <= src_g - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= have;
      busy      <= have && (src_g != 3'd0);
    end
  end

  assign empty     = !out_valid;
  assign byte_item = out_reg;

  a_grp_range: assert property (@(posedge clk) disable iff (rst) busy |-> grp <= 3'd3)
    else $error("group counter out of range");

endmodule

### rtl/dotted_oid_to_ber_encoder.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dotted_oid_to_ber_encoder
// Dotted decimal OID text in, BER OID content bytes out.
// Path: an arc finished by a taken beat is written into the arc queue, and
//   its first byte is then registered in the serialiser's output register.
// Throughput: one character per cycle while the arc queue has room for two
//   arcs; the serialiser gives one byte per cycle while bytes are popped, 1 to 5 bytes per arc.
// Reset: clears arc state, the arc queue and the output valid flag at once.
// -----------------------------------------------------------------------------
module dotted_oid_to_ber_encoder import oidber_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  char_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t byte_item
);

  arc_push_t arcs;
  arc_job_t  head;
  logic      head_valid, rd;

  oidber_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_item (char_item),
    .arcs      (arcs)
  );

  oidber_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .arcs       (arcs),
    .rd         (rd),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  oidber_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .rd         (rd),
    .pop        (pop),
    .empty      (empty),
    .byte_item  (byte_item)
  );

endmodule

### tb/sv/dotted_oid_to_ber_encoder_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dotted_oid_to_ber_encoder_tb
// Self-checking bench for the dotted OID to BER encoder. A short directed
// list covers single arcs, empty and trailing arcs, non-digit characters and
// the extreme character codes, then random identifiers with long and
// wrapping arcs and stray characters follow. Every content byte popped is
// compared with the byte list of its typed directed row or with a cycle-free
// model of the encoder, under random idling on both queue sides.
// -----------------------------------------------------------------------------
module dotted_oid_to_ber_encoder_tb import oidber_pkg::*;;

  localparam int N_RANDOM   = 450;
  localparam int QUIET_ROWS = 60;
  localparam int STALL_MAX  = 2000;
  localparam int SETTLE     = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    logic       typed;
    logic [2:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } stim_row_t;

  localparam out_item_t NO_BYTE = '0;
  localparam int N_DIRECTED = 21;

  // typed rows carry their own byte list; the rest go through the model
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{"5",    1'b1, 1'b1, 3'd1, '{8'h05, 1'b1}, NO_BYTE},
    '{CH_DOT, 1'b1, 1'b1, 3'd1, '{8'h00, 1'b1}, NO_BYTE},
    '{"1",    1'b0, 1'b1, 3'd0, NO_BYTE, NO_BYTE},
    '{CH_DOT, 1'b0, 1'b1, 3'd0, NO_BYTE, NO_BYTE},
    '{"2",    1'b1, 1'b1, 3'd1, '{8'h2A, 1'b1}, NO_BYTE},
    '{"2",    1'b0, 1'b1, 3'd0, NO_BYTE, NO_BYTE},
    '{CH_DOT, 1'b0, 1'b1, 3'd0, NO_BYTE, NO_BYTE},
    '{"3",    1'b0, 1'b1, 3'd0, NO_BYTE, NO_BYTE},
    '{CH_DOT, 1'b1, 1'b1, 3'd2, '{8'h53, 1'b0}, '{8'h00, 1'b1}},
    '{"-",    1'b0, 1'b1, 3'd0, NO_BYTE, NO_BYTE},
    '{"7",    1'b0, 1'b1, 3'd0, NO_BYTE, NO_BYTE},
    '{CH_DOT, 1'b0, 1'b1, 3'd0, NO_BYTE, NO_BYTE},
    '{"1",    1'b1, 1'b1, 3'd1, '{8'h01, 1'b1}, NO_BYTE},
    '{8'hFF,  1'b1, 1'b1, 3'd1, '{8'h00, 1'b1}, NO_BYTE},
    '{8'h00,  1'b1, 1'b1, 3'd1, '{8'h00, 1'b1}, NO_BYTE},
    '{"3",    1'b0, 1'b0, 3'd0, NO_BYTE, NO_BYTE},
    '{"9",    1'b0, 1'b0, 3'd0, NO_BYTE, NO_BYTE},
    '{CH_DOT, 1'b0, 1'b0, 3'd0, NO_BYTE, NO_BYTE},
    '{"1",    1'b0, 1'b0, 3'd0, NO_BYTE, NO_BYTE},
    '{"2",    1'b0, 1'b0, 3'd0, NO_BYTE, NO_BYTE},
    '{"8",    1'b1, 1'b0, 3'd0, NO_BYTE, NO_BYTE}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  char_item = '0;
  logic      full;
  logic      empty;
  out_item_t byte_item;

  dotted_oid_to_ber_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .char_item(char_item),
    .empty    (empty),
    .pop      (pop),
    .byte_item(byte_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder model state
  logic [31:0] arc_value = '0;
  logic        arc_closed = 1'b0;
  logic [1:0]  arcs_seen = '0;
  logic [31:0] root_arc = '0;

  out_item_t   step_bytes[$];
  out_item_t   bytes_due[$];
  stim_row_t   chars[$];

  int          taken = 0;
  int          error_count = 0;
  int          stalled_cycles = 0;
  logic        all_drained = 1'b1;
  logic        quiet_tail = 1'b0;
  int          pop_hold = 0;

  function automatic void emit_base128(input logic [31:0] v);
    int groups;
    logic [7:0] b;
    groups = v < 32'h80 ? 1 : v < 32'h4000 ? 2 : v < 32'h200000 ? 3 :
             v < 32'h10000000 ? 4 : 5;
    for (int g = groups - 1; g >= 0; g--) begin
      b = {g != 0, 7'(v >> (7 * g))};
      step_bytes.push_back('{out_byte: b, out_last: 1'b0});
    end
  endfunction

  function automatic void close_arc();
    if (arcs_seen == 2'd0) begin
      root_arc = arc_value;
    end else if (arcs_seen == 2'd1) begin
      emit_base128(32'd40 * root_arc + arc_value);
    end else begin
      emit_base128(arc_value);
    end
  endfunction

  function automatic void encode_char(input in_item_t c);
    out_item_t tail;
    step_bytes.delete();
    if (c.ch == CH_DOT) begin
      close_arc();
      if (arcs_seen < 2'd2) arcs_seen++;
      arc_value = '0;
      arc_closed = 1'b0;
    end else if (c.ch >= CH_ZERO && c.ch <= CH_NINE) begin
      if (!arc_closed) arc_value = arc_value * 32'd10 + 32'(c.ch - CH_ZERO);
    end else begin
      arc_closed = 1'b1;
    end
    if (c.is_last) begin
      if (arcs_seen == 2'd0) emit_base128(arc_value);
      else close_arc();
      if (step_bytes.size() > 0) begin
        tail = step_bytes.pop_back();
        tail.out_last = 1'b1;
        step_bytes.push_back(tail);
      end
      arc_value = '0;
      arc_closed = 1'b0;
      arcs_seen = '0;
      root_arc = '0;
    end
  endfunction

  function automatic void report(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // one identifier: mostly well formed, some stray characters, some pure noise
  function automatic void add_oid();
    int arcs;
    int len;
    int r;
    stim_row_t row;
    row = '0;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        row.ch = 8'($urandom_range(0, 255));
        row.is_last = ($urandom_range(0, 3) == 0);
        chars.push_back(row);
      end
      return;
    end
    arcs = $urandom_range(1, 6);
    for (int a = 0; a < arcs; a++) begin
      r = $urandom_range(0, 9);
      len = r < 1 ? 0 : r < 7 ? $urandom_range(1, 3) : $urandom_range(4, 11);
      for (int d = 0; d < len; d++) begin
        if ($urandom_range(0, 11) == 0) begin
          row.ch = 8'($urandom_range(0, 255));
          chars.push_back(row);
        end
        row.ch = CH_ZERO + 8'($urandom_range(0, 9));
        chars.push_back(row);
      end
      if (a < arcs - 1 || $urandom_range(0, 7) == 0) begin
        row.ch = CH_DOT;
        chars.push_back(row);
      end
    end
    if (chars.size() == 0 || chars[$].is_last) begin
      row.ch = CH_ZERO + 8'($urandom_range(0, 9));
      chars.push_back(row);
    end
    row = chars.pop_back();
    row.is_last = 1'b1;
    chars.push_back(row);
  endfunction

  // beat monitor and checker
  always @(posedge clk) begin
    stim_row_t row;
    out_item_t want;
    if (rst) begin
      stalled_cycles <= 0;
    end else begin
      if (push && !full) begin
        row = chars[taken];
        taken++;
        encode_char('{ch: row.ch, is_last: row.is_last});
        if (row.typed) begin
          if (row.n > 0) bytes_due.push_back(row.r0);
          if (row.n > 1) bytes_due.push_back(row.r1);
        end else begin
          foreach (step_bytes[k]) bytes_due.push_back(step_bytes[k]);
        end
      end
      if (pop && !empty) begin
        if (bytes_due.size() == 0) begin
          report($sformatf("unexpected beat byte=%02h last=%0b",
                           byte_item.out_byte, byte_item.out_last));
        end else begin
          want = bytes_due.pop_front();
          if (byte_item.out_byte !== want.out_byte || byte_item.out_last !== want.out_last)
            report($sformatf("byte exp %02h/%0b got %02h/%0b", want.out_byte,
                             want.out_last, byte_item.out_byte, byte_item.out_last));
        end
      end
      if ((push && !full) || (pop && !empty)) stalled_cycles <= 0;
      else stalled_cycles <= stalled_cycles + 1;
    end
    all_drained <= (bytes_due.size() == 0);
  end

  // result side idling
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      pop_hold <= $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    while (stalled_cycles < STALL_MAX) @(posedge clk);
    $display("dotted_oid_to_ber_encoder verification failed");
    $finish;
  end

  // sender
  initial begin
    int mid;
    foreach (DIRECTED[k]) chars.push_back(DIRECTED[k]);
    while (chars.size() < N_DIRECTED + N_RANDOM) add_oid();
    mid = N_DIRECTED + (chars.size() - N_DIRECTED) / 2;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < chars.size(); i++) begin
      if (i == chars.size() - QUIET_ROWS) quiet_tail <= 1'b1;
      if (i == N_DIRECTED || i == mid) begin
        push <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (!all_drained) @(posedge clk);
      end else if (i < chars.size() - QUIET_ROWS && $urandom_range(0, 4) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      push <= 1'b1;
      char_item <= '{ch: chars[i].ch, is_last: chars[i].is_last};
      do @(posedge clk); while (full);
    end
    push <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (!all_drained) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (bytes_due.size() != 0)
      report($sformatf("%0d bytes never arrived", bytes_due.size()));
    if (error_count == 0) begin
      $display("dotted_oid_to_ber_encoder verification clean");
    end else begin
      $display("dotted_oid_to_ber_encoder verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/oidber_pkg.sv
rtl/oidber_front.sv
rtl/oidber_queue.sv
rtl/oidber_back.sv
rtl/dotted_oid_to_ber_encoder.sv
tb/sv/dotted_oid_to_ber_encoder_tb.sv
